### hw/rtl/utrim_pkg.sv
// Package for the unique-run middle trimmer.
// Holds widths, saturation limits and the run-close struct shared by all modules.
// No dependencies.
package utrim_pkg;

    // Longest sequence the counters track before they saturate.
    localparam int MAX_LETTERS = 65536;

    localparam int POS_W  = (MAX_LETTERS > 2) ? $clog2(MAX_LETTERS) : 1;
    localparam int RUN_W  = $clog2(MAX_LETTERS + 1);
    localparam int KEEP_W = 16;
    localparam int OUT_W  = 16;
    // Working width of the range arithmetic.
    localparam int CALC_W = (RUN_W > OUT_W) ? RUN_W : OUT_W;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LETTERS - 1);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_LETTERS);

    // A run that closes on the current letter.
    typedef struct packed {
        logic             vld;     // a run closes on this letter
        logic             at_end;  // closed by the end of the sequence
        logic [RUN_W-1:0] run;     // length of the closed run
        logic [RUN_W-1:0] after;   // position just past the run
    } t_close;

endpackage

### hw/rtl/utrim_cnt.sv
// Position and run counters of the unique-run middle trimmer.
// Reports the run that closes on each transaction. Depends on utrim_pkg.
module utrim_cnt
    import utrim_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  logic   i_is_unique,
    input  logic   i_last_letter,
    output t_close o_close
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [RUN_W-1:0] r_run, n_run;
    logic [RUN_W-1:0] run_inc;

    always_comb begin
        run_inc = (r_run < RUN_MAX) ? (r_run + RUN_W'(1)) : r_run;

        if (i_is_unique) begin
            o_close.vld    = i_last_letter;
            o_close.at_end = 1'b1;
            o_close.run    = run_inc;
            o_close.after  = RUN_W'(r_pos) + RUN_W'(1);
        end else begin
            o_close.vld    = 1'b1;
            o_close.at_end = 1'b0;
            o_close.run    = r_run;
            o_close.after  = RUN_W'(r_pos);
        end

        if (i_last_letter) begin
            n_pos = '0;
            n_run = '0;
        end else begin
            n_pos = (r_pos < POS_MAX) ? (r_pos + POS_W'(1)) : r_pos;
            n_run = i_is_unique ? run_inc : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_run <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_run <= n_run;
        end
    end

endmodule

### hw/rtl/utrim_rng.sv
// Drop-range arithmetic of the unique-run middle trimmer.
// Turns a closed run and the kept length into a position range. Depends on utrim_pkg.
module utrim_rng
    import utrim_pkg::*;
(
    input  t_close            i_close,
    input  logic [KEEP_W-1:0] i_keep,
    output logic              o_emit,
    output logic [OUT_W-1:0]  o_start,
    output logic [OUT_W-1:0]  o_end
);

    logic [CALC_W-1:0] run, after, keep, keep_lo, keep_hi;
    logic [CALC_W-1:0] start_raw, end_raw, start_adj, end_adj;

    always_comb begin
        run     = CALC_W'(i_close.run);
        after   = CALC_W'(i_close.after);
        keep    = CALC_W'(i_keep);
        keep_lo = keep >> 1;
        keep_hi = keep - keep_lo;

        o_emit    = i_close.vld && (run > keep);
        start_raw = (run > after) ? '0 : (after - run);
        end_raw   = after - CALC_W'(1);

        // Start of sequence keeps the tail, end keeps the head, middle splits.
        if (start_raw == '0) begin
            start_adj = start_raw;
            end_adj   = end_raw - keep;
        end else if (i_close.at_end) begin
            start_adj = start_raw + keep;
            end_adj   = end_raw;
        end else begin
            start_adj = start_raw + keep_lo;
            end_adj   = end_raw - keep_hi;
        end

        o_start = start_adj[OUT_W-1:0];
        o_end   = end_adj[OUT_W-1:0];
    end

endmodule

### hw/rtl/unique_run_middle_trimmer.sv
// Top level of the unique-run middle trimmer.
// Instantiates utrim_cnt and utrim_rng; depends on utrim_pkg.
//
// Takes one letter per cycle (is_unique, last_letter) while the output is ready
// and emits at most one drop range per letter, in the cycle after the letter's
// transaction. A letter is taken whenever the result register is empty or its
// range is being taken in the same cycle, so the sustained rate is one letter
// per clock unless the output stalls; the single result register between the
// counter update and the output is what sets it. Letter positions count from
// zero and saturate at MAX_LETTERS-1; the run length saturates at MAX_LETTERS.
// Both reset after the last letter. The user must write kept_run_length through
// i_cfg_we/i_cfg_wdata only while the block is idle; the block does not enforce it.
module unique_run_middle_trimmer
    import utrim_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [KEEP_W-1:0] i_cfg_wdata,
    // letter channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_is_unique,
    input  logic              i_last_letter,
    // drop-range channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [OUT_W-1:0]  o_drop_start,
    output logic [OUT_W-1:0]  o_drop_end
);

    logic [KEEP_W-1:0] r_keep;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_start, r_end;

    logic              accept;
    t_close            close;
    logic              emit;
    logic [OUT_W-1:0]  calc_start, calc_end;

    // Take a letter while the result slot is free or draining this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    utrim_cnt u_cnt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_is_unique   (i_is_unique),
        .i_last_letter (i_last_letter),
        .o_close       (close)
    );

    utrim_rng u_rng (
        .i_close (close),
        .i_keep  (r_keep),
        .o_emit  (emit),
        .o_start (calc_start),
        .o_end   (calc_end)
    );

    // Kept run length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= '0;
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_wdata;
        end
    end

    // Result register: load on an emitting transaction, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_start <= calc_start;
            r_end   <= calc_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drop_start = r_start;
    assign o_drop_end   = r_end;

endmodule
